// ----- design/sadf_pkg.sv -----
// Package for the stack allocator: sizes, codes, payload and configuration types.
`timescale 1ns / 1ps
package sadf_pkg;

  localparam int ENTRIES = 256;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ADDR_W  = 32;
  localparam int LEN_W   = ADDR_W + 1;
  localparam int AW      = ADDR_W + 3;
  localparam int RECL_W  = 9;
  localparam int SHIFT_W = 5;
  localparam int MASK_W  = 17;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [SHIFT_W-1:0] ALIGN_MIN   = 5'd4;
  localparam logic [SHIFT_W-1:0] ALIGN_MAX   = 5'd16;
  localparam logic [SHIFT_W-1:0] ALIGN_RESET = 5'd4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_SPACE   = 2'd1,
    STAT_TABLE_FULL = 2'd2,
    STAT_NOT_FOUND  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_BASE   = 2'd0,
    REG_REGION = 2'd1,
    REG_ALIGN  = 2'd2,
    REG_GROW   = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_ALEN,
    S_RTOT,
    S_AEND,
    S_ANEXT,
    S_ACHK,
    S_SRD,
    S_SRCH,
    S_POP
  } state_t;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] byte_count;
    logic [ADDR_W-1:0] block_address;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
    logic [ADDR_W-1:0] bytes_in_use;
    logic [RECL_W-1:0] entries_reclaimed;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  base_address;
    logic [ADDR_W-1:0]  region_bytes;
    logic [SHIFT_W-1:0] align_shift;
    logic               grow_down;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
  } entry_t;

endpackage

// ----- design/sadf_alu.sv -----
// Shared add/subtract unit used by the init, allocate and pop steps of the allocator sequencer.
`timescale 1ns / 1ps
module sadf_alu (
  input  logic [sadf_pkg::AW-1:0] a,
  input  logic [sadf_pkg::AW-1:0] b,
  input  logic                    sub,
  output logic [sadf_pkg::AW-1:0] sum
);
  import sadf_pkg::*;

  // two's complement: a - b = a + ~b + 1
  logic [AW-1:0] b_op;

  assign b_op = sub ? ~b : b;
  assign sum  = a + b_op + AW'(sub);

endmodule

// ----- design/sadf_stack.sv -----
// Entry stack storage: block address and size memories with registered reads.
`timescale 1ns / 1ps
module sadf_stack (
  input  logic                       clk,
  input  logic                       we,
  input  logic [sadf_pkg::IDX_W-1:0] waddr,
  input  sadf_pkg::entry_t           wentry,
  input  logic [sadf_pkg::IDX_W-1:0] addr_ra,
  input  logic [sadf_pkg::IDX_W-1:0] size_ra,
  output logic [sadf_pkg::ADDR_W-1:0] addr_rd,
  output logic [sadf_pkg::ADDR_W-1:0] size_rd
);
  import sadf_pkg::*;

  logic [ADDR_W-1:0] addr_mem [ENTRIES];
  logic [ADDR_W-1:0] size_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      addr_mem[waddr] <= wentry.addr;
      size_mem[waddr] <= wentry.size;
    end
    addr_rd <= addr_mem[addr_ra];
    size_rd <= size_mem[size_ra];
  end

endmodule

// ----- design/sadf_regs.sv -----
// APB configuration registers of the allocator.
`timescale 1ns / 1ps
module sadf_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sadf_pkg::PADDR_W-1:0] paddr,
  input  logic [sadf_pkg::PDATA_W-1:0] pwdata,
  output logic [sadf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  output sadf_pkg::cfg_t               cfg,
  output logic                         cfg_we
);
  import sadf_pkg::*;

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= '0;
      cfg.region_bytes <= '0;
      cfg.align_shift  <= ALIGN_RESET;
      cfg.grow_down    <= 1'b0;
    end else if (cfg_we) begin
      unique case (idx)
        REG_BASE:   cfg.base_address <= pwdata[ADDR_W-1:0];
        REG_REGION: cfg.region_bytes <= pwdata[ADDR_W-1:0];
        REG_ALIGN:  cfg.align_shift  <= pwdata[SHIFT_W-1:0];
        REG_GROW:   cfg.grow_down    <= pwdata[0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE:   prdata = PDATA_W'(cfg.base_address);
      REG_REGION: prdata = PDATA_W'(cfg.region_bytes);
      REG_ALIGN:  prdata = PDATA_W'(cfg.align_shift);
      REG_GROW:   prdata = PDATA_W'(cfg.grow_down);
      default:    prdata = '0;
    endcase
  end

endmodule

// ----- design/stack_allocator_deferred_free_core.sv -----
// Top level of the stack allocator with deferred free: sequencer and datapath.
// Usage:
//   Configuration goes through the APB port (base, region size, alignment shift,
//   direction at byte addresses 0, 4, 8, 12). Any register write empties the entry
//   stack and recomputes the current pointer; the sequencer is busy meanwhile.
//   A request transaction is taken on a clock edge with start high and busy low.
//   Each request gives exactly one result transaction: done pulses for one cycle
//   with rsp valid. The receiver cannot stall; a new request may be taken in the
//   same cycle that done is high.
// Busy sequence (done is registered from the last busy step):
//   allocate: round length, round region, region end, next pointer, check and
//             commit, round length alone on a full table; one shared 35-bit adder.
//   free:     a read step, then k compares walking down from the top of the stack
//             (one per cycle through the address memory read port), then p pops
//             (one per cycle through the size memory read port). On an empty
//             stack a free ends after the read step.
// Reset: synchronous, rst high. Registers go to base 0, size 0, shift 4, upward;
//   the stack is empty and the pointer is 0. Deleted flags are flip-flops that
//   clear at once, so there is no clearing pass; stored entries hold junk until
//   written and are never read before then.
`timescale 1ns / 1ps
module stack_allocator_deferred_free_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sadf_pkg::PADDR_W-1:0] paddr,
  input  logic [sadf_pkg::PDATA_W-1:0] pwdata,
  output logic [sadf_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  input  logic                         start,
  input  sadf_pkg::in_t                req,
  output logic                         busy,
  output logic                         done,
  output sadf_pkg::out_t               rsp
);
  import sadf_pkg::*;

  // configuration
  cfg_t cfg;
  logic cfg_we;

  // control state
  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] ptr;
  logic [ADDR_W-1:0] in_use;
  logic [ENTRIES-1:0] deleted;

  // per-transaction working registers
  in_t               req_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  rt_r;
  logic [AW-1:0]     end_r;
  logic [AW-1:0]     next_r;
  logic [IDX_W-1:0]  cmp_idx;
  logic [RECL_W-1:0] popped;

  // shared adder
  logic [AW-1:0] alu_a, alu_b, alu_sum, aligned_sum, mask_n;
  logic          alu_sub;

  // alignment
  logic [SHIFT_W-1:0] shift_c;
  logic [MASK_W-1:0]  m;

  // stack memory
  logic              mem_we;
  entry_t            wentry;
  logic [IDX_W-1:0]  addr_ra, size_ra;
  logic [ADDR_W-1:0] addr_rd, size_rd;

  // derived indexes and conditions
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [IDX_W-1:0]  top_idx, below_idx, cnt_idx;
  logic              tbl_full, match, top_del, more_pop, alloc_ok;
  logic [ADDR_W-1:0] alloc_start;

  // finish signals
  logic              fin;
  out_t              fin_rsp;
  logic [ADDR_W-1:0] in_use_next;

  sadf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_we  (cfg_we)
  );

  sadf_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  sadf_stack u_stack (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (cnt_idx),
    .wentry  (wentry),
    .addr_ra (addr_ra),
    .size_ra (size_ra),
    .addr_rd (addr_rd),
    .size_rd (size_rd)
  );

  // alignment clamped to 16..64K bytes
  always_comb begin
    if (cfg.align_shift < ALIGN_MIN) begin
      shift_c = ALIGN_MIN;
    end else if (cfg.align_shift > ALIGN_MAX) begin
      shift_c = ALIGN_MAX;
    end else begin
      shift_c = cfg.align_shift;
    end
  end

  assign m           = (MASK_W'(1) << shift_c) - MASK_W'(1);
  assign mask_n      = ~AW'(m);
  assign aligned_sum = alu_sum & mask_n;

  assign busy      = (state != S_IDLE);
  assign cnt_m1    = count - CNT_W'(1);
  assign cnt_m2    = count - CNT_W'(2);
  assign top_idx   = cnt_m1[IDX_W-1:0];
  assign below_idx = cnt_m2[IDX_W-1:0];
  assign cnt_idx   = count[IDX_W-1:0];
  assign tbl_full  = (count == CNT_W'(ENTRIES));

  // search hit: live entry whose stored address matches
  assign match    = !deleted[cmp_idx] && (addr_rd == req_r.block_address);
  // after marking the hit, is the top of the stack deleted?
  assign top_del  = (cmp_idx == top_idx) || deleted[top_idx];
  // another pop follows only while the entry below the top is deleted too
  assign more_pop = (count > CNT_W'(1)) && deleted[below_idx];

  // region bounds: upward the block starts at or above base, ends below region end
  // and inside 32 bits; downward it starts at or above zero and above region end
  always_comb begin
    if (cfg.grow_down) begin
      alloc_ok    = !next_r[AW-1] && ($signed(next_r) > $signed(end_r));
      alloc_start = next_r[ADDR_W-1:0];
    end else begin
      alloc_ok    = (ptr >= cfg.base_address) && ($signed(next_r) < $signed(end_r))
                    && (next_r[AW-1:ADDR_W] == '0);
      alloc_start = ptr;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    if (cfg_we) begin
      state_next = S_INIT;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state_next = (req.action == ACT_FREE) ? S_SRD : S_ALEN;
          end
        end
        S_INIT:  state_next = S_IDLE;
        S_ALEN:  state_next = tbl_full ? S_IDLE : S_RTOT;
        S_RTOT:  state_next = S_AEND;
        S_AEND:  state_next = S_ANEXT;
        S_ANEXT: state_next = S_ACHK;
        S_ACHK:  state_next = S_IDLE;
        S_SRD:   state_next = (count == '0) ? S_IDLE : S_SRCH;
        S_SRCH: begin
          if (match) begin
            state_next = top_del ? S_POP : S_IDLE;
          end else if (cmp_idx == '0) begin
            state_next = S_IDLE;
          end
        end
        S_POP:   state_next = more_pop ? S_POP : S_IDLE;
        default: state_next = S_IDLE;
      endcase
    end
  end

  // sequencer outputs: adder operands, memory ports, finish
  always_comb begin
    alu_a       = '0;
    alu_b       = '0;
    alu_sub     = 1'b0;
    addr_ra     = top_idx;
    size_ra     = top_idx;
    mem_we      = 1'b0;
    wentry.addr = alloc_start;
    wentry.size = len_r[ADDR_W-1:0];
    fin         = 1'b0;
    in_use_next = in_use;
    fin_rsp.result_address    = '0;
    fin_rsp.status            = STAT_OK;
    fin_rsp.entries_reclaimed = '0;
    unique case (state)
      S_IDLE: ;
      S_INIT: begin
        alu_a = AW'(cfg.base_address);
        alu_b = AW'(m);
      end
      S_ALEN: begin
        alu_a = AW'(req_r.byte_count);
        alu_b = AW'(m);
        if (tbl_full) begin
          fin            = 1'b1;
          fin_rsp.status = STAT_TABLE_FULL;
        end
      end
      S_RTOT: begin
        alu_a = AW'(cfg.region_bytes);
        alu_b = AW'(m);
      end
      S_AEND: begin
        alu_a   = AW'(cfg.base_address);
        alu_b   = AW'(rt_r);
        alu_sub = cfg.grow_down;
      end
      S_ANEXT: begin
        alu_a   = AW'(ptr);
        alu_b   = AW'(len_r);
        alu_sub = cfg.grow_down;
      end
      S_ACHK: begin
        fin = 1'b1;
        if (alloc_ok) begin
          mem_we                 = 1'b1;
          in_use_next            = in_use + len_r[ADDR_W-1:0];
          fin_rsp.result_address = alloc_start;
        end else begin
          fin_rsp.status = STAT_NO_SPACE;
        end
      end
      S_SRD: begin
        if (count == '0) begin
          fin            = 1'b1;
          fin_rsp.status = STAT_NOT_FOUND;
        end
      end
      S_SRCH: begin
        addr_ra = cmp_idx - IDX_W'(1);
        if (match) begin
          fin = !top_del;
        end else if (cmp_idx == '0) begin
          fin            = 1'b1;
          fin_rsp.status = STAT_NOT_FOUND;
        end
      end
      S_POP: begin
        size_ra     = below_idx;
        alu_a       = AW'(ptr);
        alu_b       = AW'(size_rd);
        alu_sub     = !cfg.grow_down;
        in_use_next = in_use - size_rd;
        fin         = !more_pop;
        fin_rsp.entries_reclaimed = popped + RECL_W'(1);
      end
      default: ;
    endcase
    fin_rsp.bytes_in_use = in_use_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      ptr     <= '0;
      in_use  <= '0;
      deleted <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (cfg_we) begin
        count   <= '0;
        in_use  <= '0;
        deleted <= '0;
      end else begin
        unique case (state)
          S_INIT: begin
            ptr <= cfg.grow_down ? cfg.base_address : aligned_sum[ADDR_W-1:0];
          end
          S_ACHK: begin
            if (alloc_ok) begin
              count            <= count + CNT_W'(1);
              ptr              <= next_r[ADDR_W-1:0];
              in_use           <= in_use_next;
              deleted[cnt_idx] <= 1'b0;
            end
          end
          S_SRCH: begin
            if (match) begin
              deleted[cmp_idx] <= 1'b1;
            end
          end
          S_POP: begin
            ptr              <= alu_sum[ADDR_W-1:0];
            in_use           <= in_use_next;
            deleted[top_idx] <= 1'b0;
            count            <= cnt_m1;
          end
          default: ;
        endcase
      end
    end
  end

  // working registers and result register
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= req;
    end
    if (fin) begin
      rsp <= fin_rsp;
    end
    unique case (state)
      S_ALEN:  len_r   <= aligned_sum[LEN_W-1:0];
      S_RTOT:  rt_r    <= aligned_sum[LEN_W-1:0];
      S_AEND:  end_r   <= alu_sum;
      S_ANEXT: next_r  <= alu_sum;
      S_SRD: begin
        cmp_idx <= top_idx;
        popped  <= '0;
      end
      S_SRCH: begin
        if (!match) begin
          cmp_idx <= cmp_idx - IDX_W'(1);
        end
      end
      S_POP:   popped  <= popped + RECL_W'(1);
      default: ;
    endcase
  end

  // a taken request always leaves the sequencer busy on the next cycle
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but sequencer not busy");

  // a result only ends a busy interval
  a_done_after_busy : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without work in progress");

  // stack depth bound
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(ENTRIES))
    else $error("entry count beyond table depth");

  // failed requests report no address and no reclaim
  a_fail_clean : assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != STAT_OK) |->
      (rsp.result_address == '0 && rsp.entries_reclaimed == '0))
    else $error("failed request carries address or reclaim count");

  // popping only runs on a deleted top entry
  a_pop_deleted : assert property (@(posedge clk) disable iff (rst)
    (state == S_POP) |-> deleted[top_idx])
    else $error("pop of a live entry");

endmodule

// ----- tb/sv/tb_stack_allocator_deferred_free_core.sv -----
// Self-checking testbench for the stack allocator core: directed table, fill, random phases.
`timescale 1ns / 1ps
module tb_stack_allocator_deferred_free_core;
  import sadf_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [PDATA_W-1:0] pwdata  = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               start   = 1'b0;
  in_t                req     = '0;
  logic               busy;
  logic               done;
  out_t               rsp;

  always #2 clk = ~clk;

  stack_allocator_deferred_free_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .start   (start),
    .req     (req),
    .busy    (busy),
    .done    (done),
    .rsp     (rsp)
  );

  // ---------------------------------------------------------------------------
  // Allocator shadow: register copy plus entry stack, updated by the driver
  // at the edge where a transaction or a register write is taken.
  // ---------------------------------------------------------------------------
  logic [31:0]        reg_base   = '0;
  logic [31:0]        reg_region = '0;
  logic [SHIFT_W-1:0] reg_shift  = ALIGN_RESET;
  logic               reg_down   = 1'b0;

  logic [31:0] stk_addr [ENTRIES];
  logic [31:0] stk_size [ENTRIES];
  bit          stk_dead [ENTRIES];
  int          stk_count;
  logic [31:0] cur_ptr;
  logic [31:0] used_bytes;

  out_t rsp_due [$];   // responses still owed by the DUT, oldest first
  int   errors = 0;
  int   sent   = 0;
  bit   calm   = 1'b0; // no request gaps while set

  task automatic flag(string msg);
    errors++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  // alignment mask, shift clamped to 4..16
  function automatic logic [63:0] cur_mask();
    int s;
    s = reg_shift;
    if (s < ALIGN_MIN) s = ALIGN_MIN;
    if (s > ALIGN_MAX) s = ALIGN_MAX;
    return (64'd1 << s) - 64'd1;
  endfunction

  function automatic logic [63:0] region_span();
    return ({32'd0, reg_region} + cur_mask()) & ~cur_mask();
  endfunction

  // any register write empties the stack and recomputes the pointer
  function automatic void reset_alloc();
    logic [63:0] m;
    m = cur_mask();
    foreach (stk_dead[i]) stk_dead[i] = 1'b0;
    stk_count  = 0;
    used_bytes = '0;
    // upward start rounds the base up; a carry out of 32 bits wraps to low memory
    cur_ptr    = reg_down ? reg_base : 32'(({32'd0, reg_base} + m) & ~m);
  endfunction

  // Work out one response and advance the shadow state.
  function automatic out_t serve_request(in_t it);
    out_t        o;
    logic [63:0] m, len, nxt;
    longint      lim, n;
    bit          ok, found;
    int          i, top, popped;
    o      = '0;
    popped = 0;
    m      = cur_mask();
    if (it.action == ACT_ALLOC) begin
      len = ({32'd0, it.byte_count} + m) & ~m;
      // a full table wins over the space check, deleted entries included
      if (stk_count >= ENTRIES) begin
        o.status = STAT_TABLE_FULL;
      end else begin
        if (!reg_down) begin
          // block must end strictly below region end and inside 32 bits
          nxt = {32'd0, cur_ptr} + len;
          ok  = (cur_ptr >= reg_base) && (nxt < {32'd0, reg_base} + region_span()) &&
                (nxt <= 64'hFFFF_FFFF);
        end else begin
          // block start must stay above region end and not below zero
          lim = longint'(reg_base) - longint'(region_span());
          n   = longint'(cur_ptr) - longint'(len);
          ok  = (n >= 0) && (n > lim);
          nxt = 64'(n);
        end
        if (!ok) begin
          o.status = STAT_NO_SPACE;
        end else begin
          stk_addr[stk_count] = reg_down ? nxt[31:0] : cur_ptr;
          stk_size[stk_count] = len[31:0];
          stk_dead[stk_count] = 1'b0;
          o.result_address    = stk_addr[stk_count];
          stk_count++;
          cur_ptr    = nxt[31:0];
          used_bytes = used_bytes + len[31:0];
        end
      end
    end else begin
      // topmost live entry with that address
      found = 1'b0;
      for (i = stk_count - 1; i >= 0; i--) begin
        if (!stk_dead[i] && stk_addr[i] == it.block_address) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        o.status = STAT_NOT_FOUND;
      end else begin
        stk_dead[i] = 1'b1;
        // deferred free: pop while the top is deleted
        while (stk_count > 0 && stk_dead[stk_count-1]) begin
          top = stk_count - 1;
          if (reg_down) cur_ptr = cur_ptr + stk_size[top];
          else          cur_ptr = cur_ptr - stk_size[top];
          used_bytes    = used_bytes - stk_size[top];
          stk_dead[top] = 1'b0;
          stk_count     = top;
          popped++;
        end
      end
    end
    o.bytes_in_use      = used_bytes;
    o.entries_reclaimed = popped[RECL_W-1:0];
    return o;
  endfunction

  // random live block address, or noise when the stack holds none
  function automatic logic [31:0] pick_live();
    int live [$];
    for (int i = 0; i < stk_count; i++) if (!stk_dead[i]) live.push_back(i);
    if (live.size() == 0) return $urandom();
    return stk_addr[live[$urandom_range(0, live.size() - 1)]];
  endfunction

  function automatic in_t mk_req(logic act, logic [31:0] nbytes, logic [31:0] addr);
    in_t it;
    it.action        = act;
    it.byte_count    = nbytes;
    it.block_address = addr;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Bus-side tasks. All drive with NBAs right after a rising edge.
  // ---------------------------------------------------------------------------

  // One request transaction. A pinned row owes a hand-written response, the
  // shadow still steps so later rows stay in sync.
  task automatic send(in_t it, bit pinned = 1'b0, out_t want = '0);
    out_t calc;
    int   gap;
    start <= 1'b1;
    req   <= it;
    do @(posedge clk); while (busy);
    calc = serve_request(it);
    rsp_due.push_back(pinned ? want : calc);
    sent++;
    // mostly back to back or short gaps, now and then a long one
    if (calm || $urandom_range(0, 99) < 55) gap = 0;
    else if ($urandom_range(0, 9) < 8)     gap = $urandom_range(1, 3);
    else                                   gap = $urandom_range(5, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop requesting and wait for every owed response (bounded).
  task automatic settle();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (rsp_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (2) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    logic [31:0] held;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BASE:   reg_base   = val;
      REG_REGION: reg_region = val;
      REG_ALIGN:  reg_shift  = val[SHIFT_W-1:0];
      REG_GROW:   reg_down   = val[0];
    endcase
    reset_alloc();
    // read phase, psel stays up
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_BASE:   held = reg_base;
      REG_REGION: held = reg_region;
      REG_ALIGN:  held = 32'(reg_shift);
      REG_GROW:   held = 32'(reg_down);
    endcase
    if (prdata !== held) flag($sformatf("read-back %s got %h want %h", idx.name(), prdata, held));
    psel    <= 1'b0;
    penable <= 1'b0;
    while (busy) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Response checker: every done pulse is one transaction, compared against
  // the oldest owed response.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_t due;
    if (!rst && done) begin
      if (rsp_due.size() == 0) begin
        flag("response with no request outstanding");
      end else begin
        due = rsp_due.pop_front();
        if (rsp.result_address !== due.result_address)
          flag($sformatf("result_address got %h want %h", rsp.result_address,
                         due.result_address));
        if (rsp.status !== due.status)
          flag($sformatf("status got %0d want %0d", rsp.status, due.status));
        if (rsp.bytes_in_use !== due.bytes_in_use)
          flag($sformatf("bytes_in_use got %h want %h", rsp.bytes_in_use,
                         due.bytes_in_use));
        if (rsp.entries_reclaimed !== due.entries_reclaimed)
          flag($sformatf("entries_reclaimed got %0d want %0d", rsp.entries_reclaimed,
                         due.entries_reclaimed));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Pinned rows carry a response worked out by hand.
  // ---------------------------------------------------------------------------
  typedef struct {
    bit          is_cfg;
    reg_idx_t    idx;
    logic [31:0] val;
    in_t         item;
    bit          pinned;
    out_t        want;
  } plan_row_t;

  plan_row_t plan [$];

  function automatic void plan_cfg(reg_idx_t idx, logic [31:0] val);
    plan_row_t r;
    r        = '{idx: REG_BASE, default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    plan.push_back(r);
  endfunction

  function automatic void plan_req(logic act, logic [31:0] nbytes, logic [31:0] addr);
    plan_row_t r;
    r      = '{idx: REG_BASE, default: '0};
    r.item = mk_req(act, nbytes, addr);
    plan.push_back(r);
  endfunction

  function automatic void plan_pin(logic act, logic [31:0] nbytes, logic [31:0] addr,
                                   logic [31:0] res, status_t st, logic [31:0] used,
                                   logic [RECL_W-1:0] recl);
    plan_row_t r;
    r        = '{idx: REG_BASE, default: '0};
    r.item   = mk_req(act, nbytes, addr);
    r.pinned = 1'b1;
    r.want   = '{result_address: res, status: st, bytes_in_use: used,
                 entries_reclaimed: recl};
    plan.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int          n_items;
    int          alloc_pct;
    logic [31:0] nb;
    logic [31:0] ad;
    longint      room;

    reset_alloc();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset the region is empty: nothing fits, nothing to free
    plan_pin(ACT_ALLOC, 32'd0,         32'hFFFF_FFFF, 32'd0, STAT_NO_SPACE,  32'd0, 9'd0);
    plan_pin(ACT_FREE,  32'hFFFF_FFFF, 32'd0,         32'd0, STAT_NOT_FOUND, 32'd0, 9'd0);
    plan_pin(ACT_FREE,  32'd0,         32'hFFFF_FFFF, 32'd0, STAT_NOT_FOUND, 32'd0, 9'd0);
    // unaligned base rounds up to 0x1010, region ends at 0x1103
    plan_cfg(REG_BASE,   32'h0000_1003);
    plan_cfg(REG_REGION, 32'h0000_0100);
    plan_pin(ACT_ALLOC, 32'd1,         32'hFFFF_FFFF, 32'h1010, STAT_OK,       32'h10, 9'd0);
    plan_pin(ACT_ALLOC, 32'd0,         32'd0,         32'h1020, STAT_OK,       32'h10, 9'd0);
    plan_pin(ACT_ALLOC, 32'h20,        32'd0,         32'h1020, STAT_OK,       32'h30, 9'd0);
    plan_pin(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0,         32'd0,    STAT_NO_SPACE, 32'h30, 9'd0);
    // same address twice on the stack: the upper one goes first
    plan_pin(ACT_FREE,  32'd0, 32'h1020, 32'd0, STAT_OK,        32'h10, 9'd1);
    // out-of-order free stays reserved until the zero-size block above goes
    plan_pin(ACT_FREE,  32'd0, 32'h1010, 32'd0, STAT_OK,        32'h10, 9'd0);
    plan_pin(ACT_FREE,  32'd0, 32'h1010, 32'd0, STAT_NOT_FOUND, 32'h10, 9'd0);
    plan_pin(ACT_FREE,  32'd0, 32'h1020, 32'd0, STAT_OK,        32'h00, 9'd2);
    // fill right up to the region end, one past it, zero-size at the edge
    plan_req(ACT_ALLOC, 32'hF0, 32'd0);
    plan_req(ACT_ALLOC, 32'h01, 32'd0);
    plan_req(ACT_ALLOC, 32'h00, 32'd0);
    // downward from 0x1003, region end 0xF03 is exclusive
    plan_cfg(REG_GROW, 32'd1);
    plan_req(ACT_ALLOC, 32'h01, 32'd0);
    plan_req(ACT_ALLOC, 32'hF0, 32'd0);
    plan_req(ACT_ALLOC, 32'hE0, 32'd0);
    plan_req(ACT_FREE,  32'd0,  32'h0FF3);
    plan_req(ACT_FREE,  32'd0,  32'h0F13);
    // shift above range acts as 16, below range as 4
    plan_cfg(REG_ALIGN, 32'd31);
    plan_req(ACT_ALLOC, 32'h01, 32'd0);
    plan_cfg(REG_ALIGN, 32'd0);
    // downward from base zero: only a zero-size block fits, at address zero
    plan_cfg(REG_BASE, 32'd0);
    plan_req(ACT_ALLOC, 32'd0, 32'hFFFF_FFFF);
    plan_req(ACT_FREE,  32'd0, 32'd0);
    // upward with a base that rounds past 32 bits: pointer wraps, no space
    plan_cfg(REG_GROW, 32'd0);
    plan_cfg(REG_BASE, 32'hFFFF_FFFF);
    plan_pin(ACT_ALLOC, 32'd0, 32'd0, 32'd0, STAT_NO_SPACE, 32'd0, 9'd0);
    // top of the address space
    plan_cfg(REG_BASE, 32'hFFFF_FFE0);
    plan_req(ACT_ALLOC, 32'h10, 32'd0);
    plan_req(ACT_ALLOC, 32'h10, 32'd0);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        settle();
        reg_write(plan[r].idx, plan[r].val);
      end else begin
        send(plan[r].item, plan[r].pinned, plan[r].want);
      end
    end

    // Fill the table, hit table full, free all but the top bottom-up (no pops),
    // then free the top: the whole stack unwinds in one transaction.
    settle();
    reg_write(REG_BASE,   32'h4000_0000 | ($urandom() & 32'h0FFF_FFF0));
    reg_write(REG_REGION, 32'h0010_0000);
    reg_write(REG_ALIGN,  32'd4);
    reg_write(REG_GROW,   $urandom_range(0, 1));
    while (stk_count < ENTRIES) send(mk_req(ACT_ALLOC, $urandom_range(1, 64), $urandom()));
    repeat (2) send(mk_req(ACT_ALLOC, $urandom(), $urandom()));
    for (int j = 0; j < ENTRIES - 1; j++) send(mk_req(ACT_FREE, $urandom(), stk_addr[j]));
    // deleted entries still hold their slots
    send(mk_req(ACT_ALLOC, 32'd0, $urandom()));
    send(mk_req(ACT_FREE, $urandom(), stk_addr[ENTRIES-1]));

    // Random phases: fresh settings, then a mix of allocs and frees that
    // mostly target live blocks, with an occasional full drain.
    while (sent < 1700) begin
      settle();
      case ($urandom_range(0, 5))
        0:       ad = 32'd0;
        1:       ad = 32'hFFFF_FFFF;
        2:       ad = 32'hFFFF_F000 | ($urandom() & 32'hFFF);
        default: ad = $urandom();
      endcase
      if ($urandom_range(0, 1)) reg_write(REG_BASE, ad);
      case ($urandom_range(0, 5))
        0:       nb = 32'd0;
        1:       nb = 32'hFFFF_FFFF;
        default: nb = $urandom_range(0, 32'h4000);
      endcase
      if ($urandom_range(0, 1)) reg_write(REG_REGION, nb);
      case ($urandom_range(0, 5))
        0:       nb = $urandom_range(0, 3);
        1:       nb = $urandom_range(17, 31);
        2:       nb = 32'd16;
        default: nb = $urandom_range(4, 8);
      endcase
      // upper data bits are not part of the register
      if ($urandom_range(0, 3) == 0) nb = nb | ($urandom() & 32'hFFFF_FFE0);
      if ($urandom_range(0, 1)) reg_write(REG_ALIGN, nb);
      reg_write(REG_GROW, $urandom());

      calm      = ($urandom_range(0, 3) == 0);
      n_items   = $urandom_range(30, 150);
      alloc_pct = $urandom_range(35, 75);
      repeat (n_items) begin
        if ($urandom_range(0, 99) < alloc_pct) begin
          case ($urandom_range(0, 9))
            0: nb = $urandom();
            1: nb = 32'd0;
            2: nb = 32'hFFFF_FFFF - $urandom_range(0, 32'h1F);
            3: begin
              // sizes around what is left before the region end
              room = reg_down ?
                     longint'(cur_ptr) - longint'(reg_base) + longint'(region_span()) :
                     longint'(reg_base) + longint'(region_span()) - longint'(cur_ptr);
              nb = 32'(room - longint'($urandom_range(0, 2 * (cur_mask() + 1))));
            end
            default: nb = $urandom_range(0, 4 * (cur_mask() + 1));
          endcase
          send(mk_req(ACT_ALLOC, nb, $urandom()));
        end else begin
          case ($urandom_range(0, 9))
            0:       ad = $urandom();
            1:       ad = cur_ptr;
            default: ad = pick_live();
          endcase
          send(mk_req(ACT_FREE, $urandom(), ad));
        end
      end
      if ($urandom_range(0, 1))
        repeat (stk_count) send(mk_req(ACT_FREE, $urandom(), pick_live()));
    end
    calm = 1'b0;

    // drain, let the last transaction clear, then judge
    settle();
    repeat (20) @(posedge clk);
    if (rsp_due.size() != 0) flag($sformatf("%0d responses never arrived", rsp_due.size()));
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
